[hdl/mieu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mieu_pkg
// Shared types and codes for the integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD   = 5'd0,  CMD_ADDU = 5'd1,  CMD_ADDI = 5'd2,  CMD_ADDIU = 5'd3,
    CMD_SUB   = 5'd4,  CMD_MULT = 5'd5,  CMD_DIV  = 5'd6,  CMD_AND   = 5'd7,
    CMD_OR    = 5'd8,  CMD_ORI  = 5'd9,  CMD_XOR  = 5'd10, CMD_SLL   = 5'd11,
    CMD_SRL   = 5'd12, CMD_LUI  = 5'd13, CMD_SLT  = 5'd14, CMD_MFHI  = 5'd15,
    CMD_MFLO  = 5'd16, CMD_B    = 5'd17, CMD_BEQ  = 5'd18, CMD_BNE   = 5'd19,
    CMD_BGTZ  = 5'd20, CMD_BLEZ = 5'd21, CMD_J    = 5'd22, CMD_JAL   = 5'd23,
    CMD_JR    = 5'd24
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_DIV0 = 2'd2
  } err_t;

  localparam logic [31:0] REGION_MASK = 32'hF000_0000;
  localparam logic [4:0]  LINK_REG    = 5'd31;

  // Decoded item handed from the front end to the back end.
  typedef struct packed {
    logic [4:0]  cmd;
    logic [4:0]  dest;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [25:0] target;
    logic [31:0] pc;
    logic        is_mult;
    logic        is_div;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        pc_write;
    logic [31:0] pc_value;
    logic [1:0]  error;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DIVFIX,
    ST_OUT
  } bstate_t;

endpackage

[hdl/mips_integer_execute_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// Decoupled MIPS integer execute unit: front queue plus execute back end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | command, regs, shamt, imm, target, pc
//  out_    | output    | out_valid/out_stall| reg write, pc write, error
//
//  Steps: most commands are executed and then presented by the back end;
//  mult adds a product register and the HI/LO write; div runs the radix-2
//  restoring divider, one quotient bit per cycle over 32 bits.
//  Reset: synchronous, active low; clears queue, state, HI/LO and the
//  per-register valid bits (a register never written reads zero).
//  Stalls: the front queue keeps accepting, until full, while a result waits on out_stall.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit #(
  parameter int QDepth = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_command,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_src_reg_a,
  input  logic [4:0]  in_src_reg_b,
  input  logic [4:0]  in_shift_amount,
  input  logic [15:0] in_immediate,
  input  logic [25:0] in_jump_target,
  input  logic [31:0] in_pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_pc_write,
  output logic [31:0] out_pc_value,
  output logic [1:0]  out_error
);
  import mieu_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  // Front: accept and classify into a short queue.
  mieu_front #(.QDepth(QDepth)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_dest_reg,
    .in_src_reg_a, .in_src_reg_b, .in_shift_amount, .in_immediate,
    .in_jump_target, .in_pc, .q_valid, .q_item, .q_pop
  );

  // Back: execute and hold the result until transfer.
  mieu_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_res(res)
  );

  assign out_reg_write = res.reg_write;
  assign out_reg_index = res.reg_index;
  assign out_reg_value = res.reg_value;
  assign out_pc_write  = res.pc_write;
  assign out_pc_value  = res.pc_value;
  assign out_error     = res.error;

endmodule

[hdl/mieu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mieu_front
// Accepts items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mieu_front #(
  parameter int QDepth = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [4:0]        in_command,
  input  logic [4:0]        in_dest_reg,
  input  logic [4:0]        in_src_reg_a,
  input  logic [4:0]        in_src_reg_b,
  input  logic [4:0]        in_shift_amount,
  input  logic [15:0]       in_immediate,
  input  logic [25:0]       in_jump_target,
  input  logic [31:0]       in_pc,
  output logic              q_valid,
  output mieu_pkg::item_t   q_item,
  input  logic              q_pop
);
  import mieu_pkg::*;

  localparam int AW = (QDepth > 1) ? $clog2(QDepth) : 1;

  item_t          mem_r [QDepth];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  item_t          cls;
  logic           push;

  always_comb begin
    cls.cmd     = in_command;
    cls.dest    = in_dest_reg;
    cls.src_a   = in_src_reg_a;
    cls.src_b   = in_src_reg_b;
    cls.shamt   = in_shift_amount;
    cls.imm     = in_immediate;
    cls.target  = in_jump_target;
    cls.pc      = in_pc;
    cls.is_mult = (in_command == CMD_MULT);
    cls.is_div  = (in_command == CMD_DIV);
  end

  assign in_stall = (cnt_r == (AW+1)'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(QDepth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (rp_r == AW'(QDepth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

[hdl/mieu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mieu_back
// Executes queued items: register file, HI/LO, multiply and radix-2 divide.
// ----------------------------------------------------------------------------
module mieu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mieu_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mieu_pkg::result_t out_res
);
  import mieu_pkg::*;

  bstate_t       state_r, state_nxt;
  logic [31:0]   rf_r [32];
  logic [31:0]   rf_vld_r;
  logic [31:0]   hi_r, lo_r, hi_nxt, lo_nxt;
  logic          hilo_we;
  result_t       res_r, res_nxt;
  logic          res_ld;
  logic          rf_we;

  // Operands
  logic [31:0] a, b, simm;
  item_t       it;
  assign it   = q_item;
  assign a    = (it.src_a != 5'd0 && rf_vld_r[it.src_a]) ? rf_r[it.src_a] : '0;
  assign b    = (it.src_b != 5'd0 && rf_vld_r[it.src_b]) ? rf_r[it.src_b] : '0;
  assign simm = {{16{it.imm[15]}}, it.imm};

  // Multiplier: product registered, then written to HI/LO.
  logic signed [63:0] prod_r;
  // Divider
  logic [31:0] dq_r, drem_r, dden_r;
  logic [5:0]  dcnt_r;
  logic        dneg_q_r, dneg_r_r;
  logic [32:0] dtrial;
  logic [31:0] drem_sh;

  assign drem_sh = {drem_r[30:0], dq_r[31]};
  assign dtrial  = {1'b0, drem_sh} - {1'b0, dden_r};

  // Combinational ops
  logic [32:0] sum;
  logic [31:0] opb;
  logic        do_sub;
  result_t     r1;
  logic        wr, pw;
  logic [31:0] val, npc;
  logic [4:0]  widx;
  logic [1:0]  err;

  always_comb begin
    do_sub = (it.cmd == CMD_SUB);
    opb    = (it.cmd == CMD_ADDI || it.cmd == CMD_ADDIU) ? simm : b;
    sum    = do_sub ? ({1'b0, a} - {1'b0, opb}) : ({1'b0, a} + {1'b0, opb});
    wr = 1'b0; pw = 1'b0; val = '0; npc = '0; widx = it.dest; err = ERR_NONE;
    unique case (it.cmd) inside
      CMD_ADD, CMD_ADDI, CMD_SUB: begin
        if ((do_sub ? (a[31] ^ opb[31]) : ~(a[31] ^ opb[31])) &&
            (a[31] ^ sum[31])) begin
          err = ERR_OVF;
        end else begin
          wr = 1'b1; val = sum[31:0];
        end
      end
      CMD_ADDU, CMD_ADDIU: begin wr = 1'b1; val = sum[31:0]; end
      CMD_AND:  begin wr = 1'b1; val = a & b; end
      CMD_OR:   begin wr = 1'b1; val = a | b; end
      CMD_ORI:  begin wr = 1'b1; val = a | {16'd0, it.imm}; end
      CMD_XOR:  begin wr = 1'b1; val = a ^ b; end
      CMD_SLL:  begin wr = 1'b1; val = b << it.shamt; end
      CMD_SRL:  begin wr = 1'b1; val = b >> it.shamt; end
      CMD_LUI:  begin wr = 1'b1; val = {it.imm, 16'd0}; end
      CMD_SLT:  begin wr = 1'b1; val = {31'd0, $signed(a) < $signed(b)}; end
      CMD_MFHI: begin wr = 1'b1; val = hi_r; end
      CMD_MFLO: begin wr = 1'b1; val = lo_r; end
      CMD_B:    pw = 1'b1;
      CMD_BEQ:  pw = (a == b);
      CMD_BNE:  pw = (a != b);
      CMD_BGTZ: pw = !a[31] && (a != '0);
      CMD_BLEZ: pw = a[31] || (a == '0);
      CMD_J:    begin pw = 1'b1; npc = (it.pc & REGION_MASK) | {it.target, 2'b00}; end
      CMD_JAL:  begin
        pw = 1'b1; npc = (it.pc & REGION_MASK) | {it.target, 2'b00};
        wr = 1'b1; widx = LINK_REG; val = it.pc + 32'd4;
      end
      CMD_JR:   begin pw = 1'b1; npc = a; end
      default:  ;
    endcase
    if (pw && it.cmd >= CMD_B && it.cmd <= CMD_BLEZ) begin
      npc = it.pc + {simm[29:0], 2'b00};
    end
    if (!pw) npc = '0;
    if (widx == 5'd0) wr = 1'b0;
    if (!wr) begin widx = '0; val = '0; end
    r1.reg_write = wr;
    r1.reg_index = widx;
    r1.reg_value = val;
    r1.pc_write  = pw;
    r1.pc_value  = npc;
    r1.error     = err;
  end

  // Control
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_ld    = 1'b0;
    res_nxt   = '0;
    hilo_we   = 1'b0;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rf_we     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (it.is_mult) begin
            state_nxt = ST_MUL;
          end else if (it.is_div) begin
            if (b == '0) begin
              res_ld = 1'b1; res_nxt.error = ERR_DIV0; state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_DIV;
            end
          end else begin
            res_ld = 1'b1; res_nxt = r1; rf_we = r1.reg_write; state_nxt = ST_OUT;
          end
        end
      end
      ST_MUL: begin
        hilo_we = 1'b1; hi_nxt = prod_r[63:32]; lo_nxt = prod_r[31:0];
        res_ld = 1'b1; state_nxt = ST_OUT;
      end
      ST_DIV: begin
        if (dcnt_r == 6'd0) state_nxt = ST_DIVFIX;
      end
      ST_DIVFIX: begin
        hilo_we = 1'b1;
        lo_nxt = dneg_q_r ? (32'd0 - dq_r) : dq_r;
        hi_nxt = dneg_r_r ? (32'd0 - drem_r) : drem_r;
        res_ld = 1'b1; state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rf_vld_r <= '0;
      hi_r     <= '0;
      lo_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (rf_we) rf_vld_r[r1.reg_index] <= 1'b1;
      if (hilo_we) begin
        hi_r <= hi_nxt;
        lo_r <= lo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf_r[r1.reg_index] <= r1.reg_value;
    if (res_ld) res_r <= res_nxt;
    if (state_r == ST_IDLE) prod_r <= $signed(a) * $signed(b);
    if (state_r == ST_IDLE) begin
      dq_r     <= a[31] ? (32'd0 - a) : a;
      dden_r   <= b[31] ? (32'd0 - b) : b;
      drem_r   <= '0;
      dcnt_r   <= 6'd31;
      dneg_q_r <= a[31] ^ b[31];
      dneg_r_r <= a[31];
    end else if (state_r == ST_DIV) begin
      if (!dtrial[32]) begin
        drem_r <= dtrial[31:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= drem_sh;
        dq_r   <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_res   = res_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("pop while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r <= 6'd31))
    else $error("divide counter out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_res.reg_write && out_res.reg_index == 5'd0))
    else $error("write to register zero reported");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIPS integer execute unit. A directed block and
// a long random mix of instructions are queued, driven with random idle
// bursts, and every result transfer is checked against a built-in predictor
// that keeps its own register file and HI/LO.
// ----------------------------------------------------------------------------
module tb_top;
  import mieu_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int RandomItems   = 1100;

  typedef struct {
    logic [4:0]  cmd;
    logic [4:0]  dest;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [25:0] target;
    logic [31:0] pc;
  } instr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0]  in_command = '0;
  logic [4:0]  in_dest_reg = '0;
  logic [4:0]  in_src_reg_a = '0;
  logic [4:0]  in_src_reg_b = '0;
  logic [4:0]  in_shift_amount = '0;
  logic [15:0] in_immediate = '0;
  logic [25:0] in_jump_target = '0;
  logic [31:0] in_pc = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_reg_write;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_pc_write;
  logic [31:0] out_pc_value;
  logic [1:0]  out_error;

  mips_integer_execute_unit uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;

  instr_t  pending_instrs[$];
  result_t expected_results[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  quiet = 0;          // last part of the run: no idling
  bit  hold_sink = 0;      // long receiver hold-off request
  bit  hold_src = 0;       // sender pause until drained

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Executes one instruction on the shadow state and returns its result.
  function automatic result_t execute_instr(instr_t it);
    result_t r;
    logic [31:0] a, b, val, npc, ma, mb, q, rm;
    logic [63:0] prod;
    logic [32:0] sum;
    logic wr, pw;
    logic [4:0] widx;
    logic [1:0] err;
    a = (it.src_a == 0) ? 32'd0 : gpr[it.src_a];
    b = (it.src_b == 0) ? 32'd0 : gpr[it.src_b];
    wr = 0; pw = 0; val = 0; npc = 0; err = ERR_NONE; widx = it.dest;
    case (it.cmd)
      CMD_ADD, CMD_ADDU, CMD_ADDI, CMD_ADDIU: begin
        val = (it.cmd == CMD_ADD || it.cmd == CMD_ADDU) ? b : sx16(it.imm);
        sum = {1'b0, a} + {1'b0, val};
        if ((it.cmd == CMD_ADD || it.cmd == CMD_ADDI) &&
            (a[31] == val[31]) && (sum[31] != a[31])) begin
          err = ERR_OVF; val = 0;
        end else begin
          wr = 1; val = sum[31:0];
        end
      end
      CMD_SUB: begin
        val = a - b;
        if ((a[31] != b[31]) && (val[31] != a[31])) begin
          err = ERR_OVF; val = 0;
        end else wr = 1;
      end
      CMD_MULT: begin
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        lo_q = prod[31:0]; hi_q = prod[63:32];
      end
      CMD_DIV: begin
        if (b == 0) err = ERR_DIV0;
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb; rm = ma % mb;
          if (a[31] != b[31]) q = -q;
          if (a[31]) rm = -rm;
          lo_q = q; hi_q = rm;
        end
      end
      CMD_AND:  begin wr = 1; val = a & b; end
      CMD_OR:   begin wr = 1; val = a | b; end
      CMD_ORI:  begin wr = 1; val = a | {16'd0, it.imm}; end
      CMD_XOR:  begin wr = 1; val = a ^ b; end
      CMD_SLL:  begin wr = 1; val = b << it.shamt; end
      CMD_SRL:  begin wr = 1; val = b >> it.shamt; end
      CMD_LUI:  begin wr = 1; val = {it.imm, 16'd0}; end
      CMD_SLT:  begin wr = 1; val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; end
      CMD_MFHI: begin wr = 1; val = hi_q; end
      CMD_MFLO: begin wr = 1; val = lo_q; end
      CMD_B:    pw = 1;
      CMD_BEQ:  pw = (a == b);
      CMD_BNE:  pw = (a != b);
      CMD_BGTZ: pw = !a[31] && a != 0;
      CMD_BLEZ: pw = a[31] || a == 0;
      CMD_J:    begin pw = 1; npc = (it.pc & REGION_MASK) | {it.target, 2'b00}; end
      CMD_JAL: begin
        pw = 1; npc = (it.pc & REGION_MASK) | {it.target, 2'b00};
        wr = 1; widx = LINK_REG; val = it.pc + 32'd4;
      end
      CMD_JR:   begin pw = 1; npc = a; end
      default: ;
    endcase
    if (pw && it.cmd >= CMD_B && it.cmd <= CMD_BLEZ)
      npc = it.pc + (sx16(it.imm) << 2);
    if (!pw) npc = 0;
    if (wr && widx == 0) wr = 0;   // writes to r0 are dropped
    if (!wr) begin
      widx = 0; val = 0;
    end else gpr[widx] = val;
    r.reg_write = wr; r.reg_index = widx; r.reg_value = val;
    r.pc_write = pw; r.pc_value = npc; r.error = err;
    return r;
  endfunction

  function automatic instr_t mk(logic [4:0] c, logic [4:0] d, logic [4:0] sa,
                                logic [4:0] sb, logic [15:0] imm);
    instr_t it;
    it.cmd = c; it.dest = d; it.src_a = sa; it.src_b = sb;
    it.shamt = 5'($urandom); it.imm = imm; it.target = 26'($urandom);
    it.pc = $urandom;
    return it;
  endfunction

  // Random 32-bit value biased toward corner values.
  function automatic logic [31:0] corner32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Random instruction; most use a small register window so operands carry
  // state produced by earlier instructions.
  function automatic instr_t rand_instr();
    instr_t it;
    logic [4:0] hi_idx;
    hi_idx = ($urandom_range(0, 3) == 0) ? 5'd31 : 5'd7;
    it.cmd    = ($urandom_range(0, 40) == 0) ? 5'($urandom_range(25, 31))
                                             : 5'($urandom_range(0, 24));
    it.dest   = 5'($urandom_range(0, hi_idx));
    it.src_a  = 5'($urandom_range(0, hi_idx));
    it.src_b  = 5'($urandom_range(0, hi_idx));
    it.shamt  = 5'($urandom);
    it.imm    = 16'($urandom);
    it.target = 26'($urandom);
    it.pc     = $urandom;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    instr_t it;
    logic [31:0] v;
    for (int i = 0; i < 32; i++) gpr[i] = 0;
    hi_q = 0; lo_q = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: build corner operands with lui/ori, then overflow, r0, divide, multiply, branch and jump cases
    pending_instrs.push_back(mk(CMD_LUI, 1, 0, 0, 16'h8000));   // r1 = min neg
    pending_instrs.push_back(mk(CMD_LUI, 2, 0, 0, 16'h7FFF));
    pending_instrs.push_back(mk(CMD_ORI, 2, 2, 0, 16'hFFFF));   // r2 = max pos
    pending_instrs.push_back(mk(CMD_ADDIU, 3, 0, 0, 16'hFFFF)); // r3 = -1
    pending_instrs.push_back(mk(CMD_ADD, 4, 2, 2, 0));          // overflow
    pending_instrs.push_back(mk(CMD_ADDI, 4, 2, 0, 16'h0001));  // overflow
    pending_instrs.push_back(mk(CMD_SUB, 4, 1, 2, 0));          // overflow
    pending_instrs.push_back(mk(CMD_ADDU, 0, 2, 2, 0));         // write to r0
    pending_instrs.push_back(mk(CMD_DIV, 0, 1, 3, 0));          // min / -1
    pending_instrs.push_back(mk(CMD_MFLO, 5, 0, 0, 0));
    pending_instrs.push_back(mk(CMD_MFHI, 6, 0, 0, 0));
    pending_instrs.push_back(mk(CMD_DIV, 0, 2, 0, 0));          // zero divisor
    pending_instrs.push_back(mk(CMD_MFLO, 5, 0, 0, 0));
    pending_instrs.push_back(mk(CMD_ADDIU, 7, 0, 0, 16'hFFF9)); // r7 = -7
    pending_instrs.push_back(mk(CMD_ADDIU, 8, 0, 0, 16'h0002));
    pending_instrs.push_back(mk(CMD_DIV, 0, 7, 8, 0));          // rounding
    pending_instrs.push_back(mk(CMD_MFHI, 9, 0, 0, 0));
    pending_instrs.push_back(mk(CMD_MULT, 0, 1, 1, 0));
    pending_instrs.push_back(mk(CMD_MFHI, 9, 0, 0, 0));
    pending_instrs.push_back(mk(CMD_BEQ, 0, 3, 3, 16'h8000));   // taken, back
    pending_instrs.push_back(mk(CMD_BNE, 0, 3, 3, 16'h7FFF));   // not taken
    pending_instrs.push_back(mk(CMD_BLEZ, 0, 0, 0, 16'hFFFF));
    pending_instrs.push_back(mk(CMD_BGTZ, 0, 2, 0, 16'h0001));
    it = mk(CMD_JAL, 0, 0, 0, 0); it.target = '1; it.pc = '1;
    pending_instrs.push_back(it);
    pending_instrs.push_back(mk(CMD_JR, 0, 31, 0, 0));
    pending_instrs.push_back(mk(5'd31, 3, 1, 2, 16'hFFFF));     // no operation

    // random: seed a few registers with corner values, then a mix
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) begin
        v = corner32();
        pending_instrs.push_back(mk(CMD_LUI, 5'($urandom_range(1, 7)), 0, 0, v[31:16]));
        it = pending_instrs[$];
        pending_instrs.push_back(mk(CMD_ORI, it.dest, it.dest, 0, v[15:0]));
      end
      if (i == 300) hold_sink = 1;
      if (i == 600) begin
        wait (pending_instrs.size() == 0);
        hold_src = 1;
      end
      if (i == 900) quiet = 1;
      pending_instrs.push_back(rand_instr());
    end
    stim_done = 1;
  end

  task automatic it_drive(instr_t it);
    in_command      <= it.cmd;
    in_dest_reg     <= it.dest;
    in_src_reg_a    <= it.src_a;
    in_src_reg_b    <= it.src_b;
    in_shift_amount <= it.shamt;
    in_immediate    <= it.imm;
    in_jump_target  <= it.target;
    in_pc           <= it.pc;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued instructions, random idle bursts, one pause
  // ---------------------------------------------------------------------------
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // a transfer retires the head of the queue before the next pick
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_instr(pending_instrs.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        // previous transfer done (or nothing offered): pick next action
        if (hold_src) begin
          // pause until the block has handed back every result
          in_valid <= 1'b0;
          if (expected_results.size() == 0 && !(in_valid && !in_stall))
            hold_src = 0;
        end else if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(1, 16) - 1;
          in_valid <= 1'b0;
        end else if (pending_instrs.size() > 0) begin
          it_drive(pending_instrs[0]);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transfer; drives one long hold-off and random stall bursts
  // ---------------------------------------------------------------------------
  int sink_gap = 0;
  int hold_count = 0;
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer idx=%0d val=%h", $time,
                   out_reg_index, out_reg_value);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_reg_write !== exp_r.reg_write || out_reg_index !== exp_r.reg_index ||
              out_reg_value !== exp_r.reg_value || out_pc_write !== exp_r.pc_write ||
              out_pc_value !== exp_r.pc_value || out_error !== exp_r.error) begin
            $display("%0t: mismatch exp wr=%b idx=%0d val=%h pw=%b pc=%h err=%0d",
                     $time, exp_r.reg_write, exp_r.reg_index, exp_r.reg_value,
                     exp_r.pc_write, exp_r.pc_value, exp_r.error);
            $display("%0t:          act wr=%b idx=%0d val=%h pw=%b pc=%h err=%0d",
                     $time, out_reg_write, out_reg_index, out_reg_value,
                     out_pc_write, out_pc_value, out_error);
            errors++;
          end
        end
      end
      // long hold-off so the front queue fills and stalls the input
      if (hold_sink) begin
        out_stall <= 1'b1;
        hold_count <= hold_count + 1;
        if (hold_count == 200) hold_sink <= 0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog and end of run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    wait (stim_done && pending_instrs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
